// ===== src/ax25ui_pkg.sv =====
// ax25ui_pkg: shared types, codes and the fcs update function
// for the ax.25 ui frame builder; no dependencies
`default_nettype none

package ax25ui_pkg;

    // item kinds on the input stream
    localparam logic [2:0] KIND_START    = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
    localparam logic [2:0] KIND_CALLSIGN = 3'd2;
    localparam logic [2:0] KIND_SSID     = 3'd3;
    localparam logic [2:0] KIND_HEADER   = 3'd4;
    localparam logic [2:0] KIND_END      = 3'd5;

    // command ops between front and back
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_HEADER = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_FLAG    = 3'd0;
    localparam logic [2:0] CFG_RESET   = 3'd1;
    localparam logic [2:0] CFG_ESCAPE  = 3'd2;
    localparam logic [2:0] CFG_CONTROL = 3'd3;
    localparam logic [2:0] CFG_PID     = 3'd4;

    localparam logic [7:0] FLAG_RST    = 8'h7E;
    localparam logic [7:0] RESET_RST   = 8'h7F;
    localparam logic [7:0] ESCAPE_RST  = 8'h1B;
    localparam logic [7:0] CONTROL_RST = 8'h03;
    localparam logic [7:0] PID_RST     = 8'hF0;

    localparam logic [15:0] FCS_INIT = 16'hFFFF;
    localparam logic [15:0] FCS_POLY = 16'h8408; // 0x1021 bit reversed
    localparam logic [7:0]  SSID_FIXED = 8'h60;

    // command queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] rst;
        logic [7:0] esc;
        logic [7:0] control;
        logic [7:0] pid;
    } t_cfg;

    // one byte through the reflected crc-16, lsb first
    function automatic logic [15:0] fcs_feed(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] r;
        r = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ FCS_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ax25_ui_frame_builder.sv =====
// ax25_ui_frame_builder: top level of the ax.25 ui frame builder
// uses ax25ui_pkg, ax25ui_front, ax25ui_queue, ax25ui_back
//
// channel   direction  handshake                        payload
// s_axis    in         s_axis_tvalid / s_axis_tready    tuser kind, tdata byte, tlast last addr
// m_axis    out        m_axis_tvalid / m_axis_tready    tdata out byte, tlast last of run
// cfg       in         i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// the back end sends one word per clock when the modem takes it and the queue is not
// empty; an item causes 1 word for start, payload, callsign and ssid, 2 for header,
// 3 for end, and one more for each escaped byte
// a four-entry command queue lets input items be taken while the back end is busy
// or the output register is stalled; the output register holds one word
// synchronous active-low reset clears queue, sequencer, fcs and config registers
`default_nettype none

module ax25_ui_frame_builder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input items
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
    input  wire logic [2:0] s_axis_tuser,  // [2:0] kind
    input  wire logic       s_axis_tlast,  // last_address
    // output words
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
    output logic            m_axis_tlast,  // last_of_run
    // configuration writes
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    ax25ui_pkg::t_cfg r_cfg;
    ax25ui_pkg::t_cmd w_cmd;
    ax25ui_pkg::t_cmd w_head;
    logic             w_push;
    logic             w_pop;
    logic             w_empty;
    logic             w_full;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag    <= ax25ui_pkg::FLAG_RST;
            r_cfg.rst     <= ax25ui_pkg::RESET_RST;
            r_cfg.esc     <= ax25ui_pkg::ESCAPE_RST;
            r_cfg.control <= ax25ui_pkg::CONTROL_RST;
            r_cfg.pid     <= ax25ui_pkg::PID_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ax25ui_pkg::CFG_FLAG:    r_cfg.flag    <= i_cfg_data;
                ax25ui_pkg::CFG_RESET:   r_cfg.rst     <= i_cfg_data;
                ax25ui_pkg::CFG_ESCAPE:  r_cfg.esc     <= i_cfg_data;
                ax25ui_pkg::CFG_CONTROL: r_cfg.control <= i_cfg_data;
                ax25ui_pkg::CFG_PID:     r_cfg.pid     <= i_cfg_data;
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // front takes items whenever the queue has room
    assign s_axis_tready = !w_full;

    ax25ui_front u_front (
        .i_kind_valid   (s_axis_tvalid && !w_full),
        .i_kind         (s_axis_tuser),
        .i_data_byte    (s_axis_tdata),
        .i_last_address (s_axis_tlast),
        .o_cmd          (w_cmd),
        .o_push         (w_push)
    );

    ax25ui_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    ax25ui_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== src/ax25ui_front.sv =====
// ax25ui_front: classifies input items into queue commands
// uses ax25ui_pkg
`default_nettype none

module ax25ui_front (
    input  wire logic              i_kind_valid,
    input  wire logic [2:0]        i_kind,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_address,
    output ax25ui_pkg::t_cmd       o_cmd,
    output logic                   o_push
);

    always_comb begin
        o_cmd.op   = ax25ui_pkg::OP_BYTE;
        o_cmd.data = i_data_byte;
        o_push     = i_kind_valid;
        unique case (i_kind)
            ax25ui_pkg::KIND_START: begin
                o_cmd.op = ax25ui_pkg::OP_START;
            end
            ax25ui_pkg::KIND_PAYLOAD: begin
                o_cmd.op = ax25ui_pkg::OP_BYTE;
            end
            ax25ui_pkg::KIND_CALLSIGN: begin
                o_cmd.data = {i_data_byte[6:0], 1'b0};
            end
            ax25ui_pkg::KIND_SSID: begin
                o_cmd.data = {i_data_byte[6:0], 1'b0} | ax25ui_pkg::SSID_FIXED
                             | {7'd0, i_last_address};
            end
            ax25ui_pkg::KIND_HEADER: begin
                o_cmd.op = ax25ui_pkg::OP_HEADER;
            end
            ax25ui_pkg::KIND_END: begin
                o_cmd.op = ax25ui_pkg::OP_END;
            end
            default: begin
                // unused kinds are swallowed
                o_push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ax25ui_queue.sv =====
// ax25ui_queue: small command fifo between front and back
// uses ax25ui_pkg
`default_nettype none

module ax25ui_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ax25ui_pkg::t_cmd  i_cmd,
    input  wire logic              i_pop,
    output ax25ui_pkg::t_cmd       o_head,
    output logic                   o_empty,
    output logic                   o_full
);

    ax25ui_pkg::t_cmd r_mem [ax25ui_pkg::QDEPTH];
    logic [ax25ui_pkg::QAW-1:0] r_wr, n_wr;
    logic [ax25ui_pkg::QAW-1:0] r_rd, n_rd;
    logic [ax25ui_pkg::QAW:0]   r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (ax25ui_pkg::QAW+1)'(ax25ui_pkg::QDEPTH));
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/ax25ui_back.sv =====
// ax25ui_back: byte sequencer with escaping, fcs and output register
// uses ax25ui_pkg
`default_nettype none

module ax25ui_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ax25ui_pkg::t_cfg  i_cfg,
    input  wire ax25ui_pkg::t_cmd  i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_byte,
    output logic                   o_last
);

    logic [15:0] r_fcs;
    logic [7:0]  r_snap_hi;
    logic [1:0]  r_step;
    logic        r_esc;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    logic [7:0]  w_b;
    logic        w_raw;
    logic        w_fin;
    logic        w_need_esc;
    logic        w_load;

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    // pick the byte this step of the command stands for
    always_comb begin
        w_b   = i_head.data;
        w_raw = 1'b0;
        w_fin = 1'b1;
        unique case (i_head.op)
            ax25ui_pkg::OP_START: begin
                w_b   = i_cfg.flag;
                w_raw = 1'b1;
            end
            ax25ui_pkg::OP_BYTE: begin
                w_b = i_head.data;
            end
            ax25ui_pkg::OP_HEADER: begin
                if (r_step == 2'd0) begin
                    w_b   = i_cfg.control;
                    w_fin = 1'b0;
                end else begin
                    w_b = i_cfg.pid;
                end
            end
            ax25ui_pkg::OP_END: begin
                case (r_step)
                    2'd0: begin
                        w_b   = ~r_fcs[7:0];
                        w_fin = 1'b0;
                    end
                    2'd1: begin
                        w_b   = r_snap_hi;
                        w_fin = 1'b0;
                    end
                    default: begin
                        w_b   = i_cfg.flag;
                        w_raw = 1'b1;
                    end
                endcase
            end
            default: begin
                w_b = i_head.data;
            end
        endcase
    end

    assign w_need_esc = !w_raw && !r_esc &&
                        (w_b == i_cfg.flag || w_b == i_cfg.rst || w_b == i_cfg.esc);
    assign w_load = !i_empty && (!r_valid || i_ready);
    assign o_pop  = w_load && !w_need_esc && w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
            r_esc   <= 1'b0;
            r_fcs   <= ax25ui_pkg::FCS_INIT;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_load) begin
                if (w_need_esc) begin
                    r_esc <= 1'b1;
                end else begin
                    r_esc <= 1'b0;
                    if (i_head.op == ax25ui_pkg::OP_START) begin
                        r_fcs <= ax25ui_pkg::FCS_INIT;
                    end else if (!w_raw) begin
                        r_fcs <= ax25ui_pkg::fcs_feed(r_fcs, w_b);
                    end
                    if (w_fin) begin
                        r_step <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_need_esc ? i_cfg.esc : w_b;
            r_last <= w_fin && !w_need_esc;
            // high fcs byte comes from the register before the low byte is fed
            if (!w_need_esc && i_head.op == ax25ui_pkg::OP_END && r_step == 2'd0) begin
                r_snap_hi <= ~r_fcs[15:8];
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_ax25_ui_frame_builder.sv =====
// tb_ax25_ui_frame_builder: self-checking bench for the ax.25 ui frame builder
// drives item words and register writes, predicts every modem byte with its own fcs model
// depends on ax25ui_pkg and the ax25_ui_frame_builder rtl
module tb_ax25_ui_frame_builder;
    timeunit 1ns;
    timeprecision 1ps;

    import ax25ui_pkg::*;

    // kinds the block must ignore, and register indexes it must not decode
    localparam logic [2:0] KIND_SPARE_LO   = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI   = 3'd7;
    localparam logic [2:0] CFG_UNMAPPED_LO = 3'd5;
    localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;

    localparam int SETTLE_CYCLES = 24;    // queue depth plus a few bytes of slack
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
    localparam int RANDOM_ITEMS  = 230;
    localparam int QUIET_TAIL    = 180;   // random items after which nobody idles
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } modem_word_t;

    // block inputs, all known from time zero
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic [2:0] s_axis_tuser  = KIND_START;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tready = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic [2:0] i_cfg_index   = CFG_FLAG;
    logic [7:0] i_cfg_data    = 8'h00;

    // block outputs
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       o_cfg_ready;

    // predictor state: running fcs and the register file as last written
    logic [15:0] fcs_acc   = FCS_INIT;
    t_cfg        frame_cfg = '{flag: FLAG_RST, rst: RESET_RST, esc: ESCAPE_RST,
                               control: CONTROL_RST, pid: PID_RST};
    modem_word_t modem_bytes_due[$];

    int          fail_count    = 0;
    int          items_counted = 0;
    int          quiet_cycles  = 0;
    int unsigned stall_left    = 0;
    bit          src_gaps_on   = 1'b0;
    bit          sink_stalls_on = 1'b0;

    ax25_ui_frame_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),   // [2:0] kind
        .s_axis_tlast  (s_axis_tlast),   // last_address
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast),   // last_of_run
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------------
    // fcs and byte prediction
    // ---------------------------------------------------------------------

    // reflected crc-16, one data bit at a time, lsb first
    function automatic logic [15:0] crc16_x25_step(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ b[i];
            acc = {1'b0, acc[15:1]};
            if (fb) begin
                acc = acc ^ FCS_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void queue_raw_byte(input logic [7:0] b);
        modem_bytes_due.push_back('{out_byte: b, last_of_run: 1'b0});
    endfunction

    // frame byte: escape if special, fcs sees only the unescaped byte
    function automatic void queue_frame_byte(input logic [7:0] b);
        if (b == frame_cfg.flag || b == frame_cfg.rst || b == frame_cfg.esc) begin
            queue_raw_byte(frame_cfg.esc);
        end
        fcs_acc = crc16_x25_step(fcs_acc, b);
        queue_raw_byte(b);
    endfunction

    function automatic void predict_item(input logic [2:0] kind, input logic [7:0] data,
                                         input logic last_addr);
        int          depth_before;
        logic [15:0] fcs_out;
        modem_word_t tail;
        depth_before = modem_bytes_due.size();
        case (kind)
            KIND_START: begin
                fcs_acc = FCS_INIT;
                queue_raw_byte(frame_cfg.flag);
            end
            KIND_PAYLOAD:  queue_frame_byte(data);
            // address bytes lose bit 7 of the character
            KIND_CALLSIGN: queue_frame_byte({data[6:0], 1'b0});
            KIND_SSID:     queue_frame_byte({data[6:0], 1'b0} | SSID_FIXED | {7'd0, last_addr});
            KIND_HEADER: begin
                queue_frame_byte(frame_cfg.control);
                queue_frame_byte(frame_cfg.pid);
            end
            KIND_END: begin
                // the fcs bytes also go through the running fcs
                fcs_out = ~fcs_acc;
                queue_frame_byte(fcs_out[7:0]);
                queue_frame_byte(fcs_out[15:8]);
                queue_raw_byte(frame_cfg.flag);
            end
            default: ;
        endcase
        if (modem_bytes_due.size() > depth_before) begin
            tail = modem_bytes_due.pop_back();
            tail.last_of_run = 1'b1;
            modem_bytes_due.push_back(tail);
        end
    endfunction

    function automatic void apply_cfg_write(input logic [2:0] index, input logic [7:0] value);
        case (index)
            CFG_FLAG:    frame_cfg.flag    = value;
            CFG_RESET:   frame_cfg.rst     = value;
            CFG_ESCAPE:  frame_cfg.esc     = value;
            CFG_CONTROL: frame_cfg.control = value;
            CFG_PID:     frame_cfg.pid     = value;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // checker: one process updates the predictor and compares words, so the
    // order of prediction and comparison within an edge is fixed
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        modem_word_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_cfg_write(i_cfg_index, i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_item(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (modem_bytes_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $error("out_byte: expected none, got %02h", m_axis_tdata);
                    end
                end else begin
                    want = modem_bytes_due.pop_front();
                    if (m_axis_tdata !== want.out_byte) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $error("out_byte: expected %02h, got %02h",
                                   want.out_byte, m_axis_tdata);
                        end
                    end
                    if (m_axis_tlast !== want.last_of_run) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $error("last_of_run: expected %0b, got %0b",
                                   want.last_of_run, m_axis_tlast);
                        end
                    end
                end
            end
        end
    end

    // watchdog: ends a run that stops moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("ax25_ui_frame_builder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // modem side: stalls in bursts of random length when enabled
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------

    // one item word; valid stays high so the next call can follow back to back
    task automatic send_item(input logic [2:0] kind, input logic [7:0] data,
                             input logic last_addr);
        @(negedge i_clk);
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last_addr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (kind <= KIND_END) begin
            items_counted++;
        end
    endtask

    // occasionally slips a random word ahead of the intended one
    task automatic send_with_noise(input logic [2:0] kind, input logic [7:0] data,
                                   input logic last_addr);
        if ($urandom_range(0, 11) == 0) begin
            send_item(3'($urandom), 8'($urandom), 1'($urandom));
        end
        send_item(kind, data, last_addr);
    endtask

    // drop valid, wait for every predicted byte; settle covers ignored items in flight
    task automatic wait_settled(input bit settle);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (modem_bytes_due.size() != 0) @(posedge i_clk);
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_register(input logic [2:0] index, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // all five registers, plus junk to the undecoded indexes
    task automatic load_config(input logic [7:0] flag, input logic [7:0] rst,
                               input logic [7:0] esc, input logic [7:0] control,
                               input logic [7:0] pid);
        write_register(CFG_FLAG, flag);
        write_register(CFG_RESET, rst);
        write_register(CFG_ESCAPE, esc);
        write_register(CFG_CONTROL, control);
        write_register(CFG_PID, pid);
        for (int i = CFG_UNMAPPED_LO; i <= CFG_UNMAPPED_HI; i++) begin
            write_register(3'(i), 8'($urandom));
        end
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return frame_cfg.flag;
            1: return frame_cfg.rst;
            2: return frame_cfg.esc;
            default: return 8'($urandom);
        endcase
    endfunction

    // a character whose shifted form often lands on a special byte
    function automatic logic [7:0] pick_callsign();
        logic [7:0] target;
        case ($urandom_range(0, 5))
            0: target = frame_cfg.flag;
            1: target = frame_cfg.rst;
            2: target = frame_cfg.esc;
            default: return 8'($urandom_range(8'h30, 8'h5A));
        endcase
        return {1'($urandom), target[7:1]};
    endfunction

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // right after reset: no start yet, so bytes run on the reset fcs
    task automatic test_outside_frame();
        send_item(KIND_PAYLOAD, FLAG_RST, 1'b1);
        send_item(KIND_CALLSIGN, 8'hC1, 1'b0);
        send_item(KIND_END, 8'h00, 1'b1);
        wait_settled(1'b1);
    endtask

    // field extremes, every kind, ignored kinds, repeated end, traffic after end
    task automatic test_field_extremes();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        load_config(FLAG_RST, RESET_RST, ESCAPE_RST, CONTROL_RST, PID_RST);
        send_item(KIND_START, 8'hFF, 1'b1);
        send_item(KIND_CALLSIGN, 8'h00, 1'b1);
        send_item(KIND_CALLSIGN, 8'hFF, 1'b0);
        send_item(KIND_CALLSIGN, 8'h3F, 1'b0);     // shifts onto the flag
        send_item(KIND_CALLSIGN, 8'hBF, 1'b1);     // same, bit 7 dropped
        send_item(KIND_SSID, 8'h00, 1'b0);
        send_item(KIND_SSID, 8'h0F, 1'b1);
        send_item(KIND_SSID, 8'hFF, 1'b1);         // ssid above 15 is not masked
        send_item(KIND_HEADER, 8'hA5, 1'b1);
        send_item(KIND_PAYLOAD, 8'h00, 1'b0);
        send_item(KIND_PAYLOAD, 8'hFF, 1'b1);
        send_item(KIND_PAYLOAD, RESET_RST, 1'b0);
        send_item(KIND_PAYLOAD, ESCAPE_RST, 1'b1);
        send_item(KIND_SPARE_LO, 8'h7E, 1'b1);     // ignored
        send_item(KIND_SPARE_HI, 8'hFF, 1'b0);     // ignored
        send_item(KIND_END, 8'h55, 1'b1);
        send_item(KIND_END, 8'h00, 1'b0);          // second end reuses the updated fcs
        send_item(KIND_PAYLOAD, 8'h42, 1'b0);      // after the frame closed
        send_item(KIND_END, 8'h00, 1'b0);
        wait_settled(1'b1);
    endtask

    // register values at the edges, including all specials on one value
    task automatic test_register_extremes();
        for (int setting = 0; setting < 4; setting++) begin
            case (setting)
                0: load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                1: load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2: load_config(8'h00, 8'hFF, 8'h80, 8'h80, 8'h00);
                default: load_config(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h01);
            endcase
            send_item(KIND_START, 8'h00, 1'b0);
            send_item(KIND_HEADER, 8'h00, 1'b0);
            send_item(KIND_PAYLOAD, frame_cfg.flag, 1'b1);
            send_item(KIND_PAYLOAD, frame_cfg.rst, 1'b0);
            send_item(KIND_PAYLOAD, frame_cfg.esc, 1'b1);
            send_item(KIND_CALLSIGN, 8'h80, 1'b0);
            send_item(KIND_SSID, 8'h10, 1'b1);
            send_item(KIND_END, 8'hFF, 1'b1);
            wait_settled(1'b1);
        end
    endtask

    // mostly well-formed frames with random content, some noise and broken frames
    task automatic test_random_frames();
        int first_item;
        int frame_no;
        int n_addr;
        int n_chars;
        int n_payload;
        first_item = items_counted;
        frame_no   = 0;
        while (items_counted - first_item < RANDOM_ITEMS) begin
            // idling varies per frame, then stops for the tail of the run
            if (items_counted - first_item >= QUIET_TAIL) begin
                src_gaps_on    = 1'b0;
                sink_stalls_on = 1'b0;
            end else begin
                src_gaps_on    = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (frame_no % 4 == 0) begin
                wait_settled(1'b1);
                if (frame_no == 0) begin
                    load_config(FLAG_RST, RESET_RST, ESCAPE_RST, CONTROL_RST, PID_RST);
                end else begin
                    load_config(8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom));
                end
            end
            // a missing start leaves the previous fcs running
            if ($urandom_range(0, 9) != 0) begin
                send_with_noise(KIND_START, 8'($urandom), 1'($urandom));
            end
            n_addr = $urandom_range(1, 2);
            for (int a = 0; a < n_addr; a++) begin
                n_chars = $urandom_range(1, 6);
                for (int c = 0; c < n_chars; c++) begin
                    send_with_noise(KIND_CALLSIGN, pick_callsign(), 1'($urandom));
                end
                send_with_noise(KIND_SSID,
                                ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 15)),
                                (a == n_addr - 1) ? 1'b1 : 1'b0);
            end
            // sender holds off until the modem has everything so far
            if (frame_no == 2) begin
                wait_settled(1'b0);
            end
            send_with_noise(KIND_HEADER, 8'($urandom), 1'($urandom));
            n_payload = $urandom_range(0, 8);
            for (int p = 0; p < n_payload; p++) begin
                send_with_noise(KIND_PAYLOAD, pick_payload(), 1'($urandom));
            end
            if ($urandom_range(0, 9) != 0) begin
                send_with_noise(KIND_END, 8'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 7) == 0) begin
                send_item(KIND_END, 8'($urandom), 1'($urandom));
            end
            frame_no++;
        end
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_outside_frame();
        test_field_extremes();
        test_register_extremes();
        test_random_frames();

        wait_settled(1'b1);
        if (fail_count == 0) begin
            $display("ax25_ui_frame_builder verification clean");
        end else begin
            $display("ax25_ui_frame_builder verification failed");
        end
        $finish;
    end

endmodule
